FILE: hdl/rsq_pkg.sv
// Package for the range add / range sum store.
// Holds the command encoding, the queue entry struct and the state machine types.
// Depends on nothing; the top level, front end, back end and testbench import it.
package rsq_pkg;

    localparam int POS_W = 18;
    localparam int ADD_W = 32;
    localparam int TOT_W = 64;

    // Item kinds as they arrive on the input.
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_SUM   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Operations after classification by the front end.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUM,
        OP_CLEAR,
        OP_NOP,
        OP_ERR
    } t_op;

    // One entry of the command queue. Positions are 0-based element addresses.
    typedef struct packed {
        t_op                      op;
        logic [POS_W-1:0]         lo0;
        logic [POS_W-1:0]         hi0;
        logic [POS_W-1:0]         blk_lo;
        logic [POS_W-1:0]         off_lo;
        logic [POS_W-1:0]         blk_hi;
        logic [POS_W-1:0]         off_hi;
        logic signed [ADD_W-1:0]  addend;
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_CLR,
        B_IDLE,
        B_SEGRD,
        B_WALK,
        B_MUL,
        B_APPLY,
        B_WHRD,
        B_WHEX,
        B_WHACC,
        B_DONE
    } t_bstate;

endpackage

FILE: hdl/range_add_range_sum_store.sv
// Range add / range sum store: top level joining the front end and the back end.
// The front end takes each item through its idle and push states, and add and sum items also
// through its divide state. The back end walks the partial blocks element by element, one
// element a cycle, and handles each whole block through its sum and pending fields. Items run
// one at a time in the back end; a new one starts once the last is done. Clear sweeps
// all memories. Reset runs the same sweep; up to three items are taken and held meanwhile,
// none is carried out until it ends. The length register resets to 131072.
module range_add_range_sum_store
    import rsq_pkg::*;
#(
    parameter int MAX_LEN     = 131072,
    parameter int BLOCK_LEN   = 256,
    parameter int BLOCK_COUNT = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       i_kind,
    input  logic [POS_W-1:0] i_left,
    input  logic [POS_W-1:0] i_right,
    input  logic [ADD_W-1:0] i_addend,
    output logic             empty,
    input  logic             pop,
    output logic [TOT_W-1:0] o_total,
    output logic             o_status,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [POS_W-1:0] i_cfg_length
);

    // The front end classifies each transfer: bounds are ordered and checked
    // against the effective length, and each bound is split into a block index
    // and an offset. Commands wait in a two-entry queue so the front end can take
    // the next transfer while the back end is still walking memory.
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;
    logic res_valid;

    rsq_front #(
        .MAX_LEN     (MAX_LEN),
        .BLOCK_LEN   (BLOCK_LEN),
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_left       (i_left),
        .i_right      (i_right),
        .i_addend     (i_addend),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_length (i_cfg_length),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    // The back end walks the partial blocks at both ends element by element and
    // handles whole blocks through their sum and pending fields. Its result
    // register holds a finished result until it is popped.
    rsq_back #(
        .MAX_LEN     (MAX_LEN),
        .BLOCK_LEN   (BLOCK_LEN),
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .pop         (pop),
        .o_res_valid (res_valid),
        .o_total     (o_total),
        .o_status    (o_status)
    );

    assign empty = !res_valid;

endmodule

FILE: hdl/rsq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the element, block sum and block pending stores. No dependencies.
module rsq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/rsq_front.sv
// Front end: takes items, orders and checks the bounds, finds block and offset of
// each bound by reciprocal multiplication, and holds a two-entry command queue.
// Depends on rsq_pkg.
module rsq_front
    import rsq_pkg::*;
#(
    parameter int MAX_LEN     = 131072,
    parameter int BLOCK_LEN   = 256,
    parameter int BLOCK_COUNT = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       i_kind,
    input  logic [POS_W-1:0] i_left,
    input  logic [POS_W-1:0] i_right,
    input  logic [ADD_W-1:0] i_addend,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [POS_W-1:0] i_cfg_length,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  logic             i_cmd_pop
);

    localparam longint BLK_SPAN = longint'(BLOCK_LEN) * longint'(BLOCK_COUNT);
    localparam longint CAP_N    = (BLK_SPAN < longint'(MAX_LEN)) ? BLK_SPAN
                                                                 : longint'(MAX_LEN);
    localparam logic [POS_W-1:0] BL18 = POS_W'(BLOCK_LEN);
    // Rounded-up reciprocal of the block length; exact for every POS_W-bit position.
    localparam int     DIV_SH  = POS_W + $clog2(BLOCK_LEN);
    localparam longint DIV_M   = ((longint'(1) << DIV_SH) + longint'(BLOCK_LEN) - 1)
                                 / longint'(BLOCK_LEN);
    localparam logic [POS_W:0] DIV_MUL = (POS_W+1)'(DIV_M);

    t_fstate          r_fstate, n_fstate;
    t_cmd             r_cur, n_cur;
    logic [POS_W-1:0] r_rem_lo, n_rem_lo;
    logic [POS_W-1:0] r_rem_hi, n_rem_hi;
    logic [POS_W-1:0] r_length;
    t_cmd             r_q0, r_q1;
    logic [1:0]       r_qcnt;

    logic [POS_W-1:0] lo, hi;
    logic [31:0]      eff_n;
    logic             bad;
    logic             q_push, q_pop;
    t_cmd             push_cmd;
    logic [2*POS_W:0] prod_lo, prod_hi;
    logic [POS_W-1:0] quo_lo, quo_hi;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= POS_W'(131072);
        end else if (i_cfg_valid) begin
            r_length <= i_cfg_length;
        end
    end

    assign lo    = (i_right < i_left) ? i_right : i_left;
    assign hi    = (i_right < i_left) ? i_left : i_right;
    assign eff_n = (32'(r_length) > 32'(CAP_N)) ? 32'(CAP_N) : 32'(r_length);
    assign bad   = (lo == '0) || (32'(hi) > eff_n);

    assign prod_lo = {{(POS_W+1){1'b0}}, r_rem_lo} * {{POS_W{1'b0}}, DIV_MUL};
    assign prod_hi = {{(POS_W+1){1'b0}}, r_rem_hi} * {{POS_W{1'b0}}, DIV_MUL};
    assign quo_lo  = POS_W'(prod_lo >> DIV_SH);
    assign quo_hi  = POS_W'(prod_hi >> DIV_SH);

    always_comb begin
        n_fstate = r_fstate;
        n_cur    = r_cur;
        n_rem_lo = r_rem_lo;
        n_rem_hi = r_rem_hi;
        case (r_fstate)
            F_IDLE: begin
                if (push) begin
                    n_cur.lo0    = lo - 1'b1;
                    n_cur.hi0    = hi - 1'b1;
                    n_cur.blk_lo = '0;
                    n_cur.blk_hi = '0;
                    n_cur.off_lo = '0;
                    n_cur.off_hi = '0;
                    n_cur.addend = i_addend;
                    n_rem_lo     = lo - 1'b1;
                    n_rem_hi     = hi - 1'b1;
                    n_fstate     = F_PUSH;
                    case (i_kind)
                        KIND_CLEAR: n_cur.op = OP_CLEAR;
                        KIND_NONE:  n_cur.op = OP_NOP;
                        KIND_ADD, KIND_SUM: begin
                            if (bad) begin
                                n_cur.op = OP_ERR;
                            end else begin
                                n_cur.op = (i_kind == KIND_ADD) ? OP_ADD : OP_SUM;
                                n_fstate = F_DIV;
                            end
                        end
                        default: n_cur.op = OP_NOP;
                    endcase
                end
            end
            F_DIV: begin
                // Block index from the reciprocal product, offset by one subtraction.
                n_cur.blk_lo = quo_lo;
                n_cur.blk_hi = quo_hi;
                n_rem_lo     = r_rem_lo - quo_lo * BL18;
                n_rem_hi     = r_rem_hi - quo_hi * BL18;
                n_fstate     = F_PUSH;
            end
            F_PUSH: begin
                if (r_qcnt != 2'd2) begin
                    n_fstate = F_IDLE;
                end
            end
            default: n_fstate = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstate <= F_IDLE;
        end else begin
            r_fstate <= n_fstate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_rem_lo <= n_rem_lo;
        r_rem_hi <= n_rem_hi;
    end

    assign full = (r_fstate != F_IDLE);

    // Two-entry queue; entry 0 is the head.
    always_comb begin
        push_cmd        = r_cur;
        push_cmd.off_lo = r_rem_lo;
        push_cmd.off_hi = r_rem_hi;
    end

    assign q_push      = (r_fstate == F_PUSH) && (r_qcnt != 2'd2);
    assign q_pop       = i_cmd_pop && (r_qcnt != 2'd0);
    assign o_cmd_valid = (r_qcnt != 2'd0);
    assign o_cmd       = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= 2'd0;
        end else begin
            r_qcnt <= r_qcnt + 2'(q_push) - 2'(q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push && ((r_qcnt - 2'(q_pop)) == 2'd0)) begin
            r_q0 <= push_cmd;
        end else if (q_pop) begin
            r_q0 <= r_q1;
        end
        if (q_push && ((r_qcnt - 2'(q_pop)) != 2'd0)) begin
            r_q1 <= push_cmd;
        end
    end

    a_qcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= 2'd2)
        else $error("command queue count out of range");

    a_div_only_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fstate == F_DIV |-> (r_cur.op == OP_ADD || r_cur.op == OP_SUM))
        else $error("block search running for an item without a range");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fstate == F_PUSH && $past(r_fstate) == F_DIV)
            |-> (r_rem_lo < BL18 && r_rem_hi < BL18))
        else $error("block offsets not reduced below the block length");

endmodule

FILE: hdl/rsq_back.sv
// Back end: carries out queued commands against the element, block sum and block
// pending memories and holds the one-entry result register.
// Depends on rsq_pkg and rsq_ram.
module rsq_back
    import rsq_pkg::*;
#(
    parameter int MAX_LEN     = 131072,
    parameter int BLOCK_LEN   = 256,
    parameter int BLOCK_COUNT = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    input  logic             pop,
    output logic             o_res_valid,
    output logic [TOT_W-1:0] o_total,
    output logic             o_status
);

    localparam int AW    = $clog2(MAX_LEN);
    localparam int BW    = $clog2(BLOCK_COUNT);
    localparam int CW    = $clog2(BLOCK_LEN) + 1;
    localparam int SWEEP = (MAX_LEN > BLOCK_COUNT) ? MAX_LEN : BLOCK_COUNT;
    localparam int PW    = $clog2(SWEEP);

    t_bstate          r_state, n_state;
    logic             r_is_add, n_is_add;
    logic [TOT_W-1:0] r_a, n_a;
    logic [AW-1:0]    r_p, n_p;
    logic [AW-1:0]    r_end, n_end;
    logic [AW-1:0]    r_hi_end, n_hi_end;
    logic [AW-1:0]    r_seg2, n_seg2;
    logic [BW-1:0]    r_blk, n_blk;
    logic [BW-1:0]    r_blk_hi, n_blk_hi;
    logic             r_two, n_two;
    logic             r_second, n_second;
    logic             r_issuing, n_issuing;
    logic             r_v1, n_v1;
    logic [AW-1:0]    r_a1, n_a1;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [TOT_W-1:0] r_acc, n_acc;
    logic [TOT_W-1:0] r_prod, n_prod;
    logic             r_stat, n_stat;
    logic [PW-1:0]    r_clr_ptr, n_clr_ptr;
    logic             r_reply, n_reply;
    logic             r_res_valid;
    logic [TOT_W-1:0] r_total;
    logic             r_status;

    logic             elem_we;
    logic [AW-1:0]    elem_waddr;
    logic [TOT_W-1:0] elem_wdata, elem_rdata;
    logic             pend_we, sums_we;
    logic [BW-1:0]    blk_waddr;
    logic [TOT_W-1:0] pend_wdata, pend_rdata, sums_wdata, sums_rdata;
    logic             res_load;
    logic [TOT_W-1:0] mul_a;
    logic             next_whole, first_whole;

    rsq_ram #(.WIDTH(TOT_W), .DEPTH(MAX_LEN)) u_elem (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (elem_waddr),
        .i_wdata (elem_wdata),
        .i_raddr (r_p),
        .o_rdata (elem_rdata)
    );

    rsq_ram #(.WIDTH(TOT_W), .DEPTH(BLOCK_COUNT)) u_pend (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (blk_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (r_blk),
        .o_rdata (pend_rdata)
    );

    rsq_ram #(.WIDTH(TOT_W), .DEPTH(BLOCK_COUNT)) u_sums (
        .i_clk   (i_clk),
        .i_we    (sums_we),
        .i_waddr (blk_waddr),
        .i_wdata (sums_wdata),
        .i_raddr (r_blk),
        .o_rdata (sums_rdata)
    );

    assign mul_a       = r_is_add ? r_a : pend_rdata;
    assign next_whole  = (({1'b0, r_blk} + 1'b1) < {1'b0, r_blk_hi});
    assign first_whole = next_whole;

    always_comb begin
        n_state    = r_state;
        n_is_add   = r_is_add;
        n_a        = r_a;
        n_p        = r_p;
        n_end      = r_end;
        n_hi_end   = r_hi_end;
        n_seg2     = r_seg2;
        n_blk      = r_blk;
        n_blk_hi   = r_blk_hi;
        n_two      = r_two;
        n_second   = r_second;
        n_issuing  = r_issuing;
        n_v1       = r_v1;
        n_a1       = r_a1;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_prod     = r_prod;
        n_stat     = r_stat;
        n_clr_ptr  = r_clr_ptr;
        n_reply    = r_reply;
        elem_we    = 1'b0;
        elem_waddr = r_a1;
        elem_wdata = elem_rdata + r_a;
        pend_we    = 1'b0;
        sums_we    = 1'b0;
        blk_waddr  = r_blk;
        pend_wdata = pend_rdata + r_a;
        sums_wdata = sums_rdata + r_prod;
        o_cmd_pop  = 1'b0;
        res_load   = 1'b0;
        case (r_state)
            B_CLR: begin
                elem_we    = (32'(r_clr_ptr) < 32'(MAX_LEN));
                elem_waddr = AW'(r_clr_ptr);
                elem_wdata = '0;
                pend_we    = (32'(r_clr_ptr) < 32'(BLOCK_COUNT));
                sums_we    = pend_we;
                blk_waddr  = BW'(r_clr_ptr);
                pend_wdata = '0;
                sums_wdata = '0;
                if (32'(r_clr_ptr) == 32'(SWEEP - 1)) begin
                    n_acc   = '0;
                    n_stat  = 1'b0;
                    n_state = r_reply ? B_DONE : B_IDLE;
                end else begin
                    n_clr_ptr = r_clr_ptr + 1'b1;
                end
            end
            B_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_acc     = '0;
                    n_stat    = 1'b0;
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_reply   = 1'b1;
                            n_clr_ptr = '0;
                            n_state   = B_CLR;
                        end
                        OP_ERR: begin
                            n_stat  = 1'b1;
                            n_state = B_DONE;
                        end
                        OP_ADD, OP_SUM: begin
                            n_is_add = (i_cmd.op == OP_ADD);
                            n_a      = {{(TOT_W-ADD_W){i_cmd.addend[ADD_W-1]}}, i_cmd.addend};
                            n_p      = AW'(i_cmd.lo0);
                            n_blk    = BW'(i_cmd.blk_lo);
                            n_blk_hi = BW'(i_cmd.blk_hi);
                            n_two    = (i_cmd.blk_lo != i_cmd.blk_hi);
                            n_end    = (i_cmd.blk_lo != i_cmd.blk_hi)
                                     ? AW'(i_cmd.lo0 + (POS_W'(BLOCK_LEN - 1) - i_cmd.off_lo))
                                     : AW'(i_cmd.hi0);
                            n_hi_end = AW'(i_cmd.hi0);
                            n_seg2   = AW'(i_cmd.hi0 - i_cmd.off_hi);
                            n_second = 1'b0;
                            n_state  = B_SEGRD;
                        end
                        default: n_state = B_DONE;
                    endcase
                end
            end
            B_SEGRD: begin
                n_cnt     = CW'(r_end - r_p + 1'b1);
                n_issuing = 1'b1;
                n_v1      = 1'b0;
                n_state   = B_WALK;
            end
            B_WALK: begin
                if (r_issuing) begin
                    n_v1 = 1'b1;
                    n_a1 = r_p;
                    if (r_p == r_end) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_p = r_p + 1'b1;
                    end
                end else begin
                    n_v1 = 1'b0;
                end
                if (r_v1) begin
                    if (r_is_add) begin
                        elem_we = 1'b1;
                    end else begin
                        n_acc = r_acc + elem_rdata;
                    end
                end
                if (!r_issuing && !r_v1) begin
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_prod  = mul_a * TOT_W'(r_cnt);
                n_state = B_APPLY;
            end
            B_APPLY: begin
                if (r_is_add) begin
                    sums_we = 1'b1;
                end else begin
                    n_acc = r_acc + r_prod;
                end
                if (r_two && !r_second) begin
                    if (first_whole) begin
                        n_blk   = r_blk + 1'b1;
                        n_state = B_WHRD;
                    end else begin
                        n_second = 1'b1;
                        n_blk    = r_blk_hi;
                        n_p      = r_seg2;
                        n_end    = r_hi_end;
                        n_state  = B_SEGRD;
                    end
                end else begin
                    n_state = B_DONE;
                end
            end
            B_WHRD: begin
                n_state = B_WHEX;
            end
            B_WHEX: begin
                if (r_is_add) begin
                    pend_we = 1'b1;
                    if (next_whole) begin
                        n_blk   = r_blk + 1'b1;
                        n_state = B_WHRD;
                    end else begin
                        n_second = 1'b1;
                        n_blk    = r_blk_hi;
                        n_p      = r_seg2;
                        n_end    = r_hi_end;
                        n_state  = B_SEGRD;
                    end
                end else begin
                    n_prod  = pend_rdata * TOT_W'(BLOCK_LEN);
                    n_state = B_WHACC;
                end
            end
            B_WHACC: begin
                n_acc = r_acc + r_prod + sums_rdata;
                if (next_whole) begin
                    n_blk   = r_blk + 1'b1;
                    n_state = B_WHRD;
                end else begin
                    n_second = 1'b1;
                    n_blk    = r_blk_hi;
                    n_p      = r_seg2;
                    n_end    = r_hi_end;
                    n_state  = B_SEGRD;
                end
            end
            B_DONE: begin
                if (!r_res_valid) begin
                    res_load = 1'b1;
                    n_reply  = 1'b0;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLR;
            r_clr_ptr   <= '0;
            r_reply     <= 1'b0;
            r_issuing   <= 1'b0;
            r_v1        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_ptr <= n_clr_ptr;
            r_reply   <= n_reply;
            r_issuing <= n_issuing;
            r_v1      <= n_v1;
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_add <= n_is_add;
        r_a      <= n_a;
        r_p      <= n_p;
        r_end    <= n_end;
        r_hi_end <= n_hi_end;
        r_seg2   <= n_seg2;
        r_blk    <= n_blk;
        r_blk_hi <= n_blk_hi;
        r_two    <= n_two;
        r_second <= n_second;
        r_a1     <= n_a1;
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_stat   <= n_stat;
        if (res_load) begin
            r_total  <= r_acc;
            r_status <= r_stat;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_total     = r_total;
    assign o_status    = r_status;

    a_walk_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_WALK && r_v1 && r_issuing) |-> (r_a1 != r_p))
        else $error("element write collides with the element being read");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DONE && !r_res_valid) |=> r_res_valid)
        else $error("finished command did not reach the result register");

    a_walk_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_WALK && !r_issuing) |=> !r_v1)
        else $error("element pipeline still busy after the walk ended");

endmodule

FILE: sim/range_add_range_sum_store_test.sv
// Testbench for the range add / range sum store: random and directed range items.
// Depends on rsq_pkg and range_add_range_sum_store; predicts every result with a flat
// element array and checks each transfer on the result side field by field.
`timescale 1ns / 100ps

module range_add_range_sum_store_test;
    import rsq_pkg::*;

    localparam int STORE_LEN = 131072;

    // Expected outcome of one item on the result side.
    typedef struct {
        logic [TOT_W-1:0] total;
        logic             status;
    } t_answer;

    // Scoreboard: keeps a plain copy of every element. Whole-block bookkeeping in the
    // block does not change any total, so a flat array predicts the same wrapped sums.
    class range_scoreboard;
        logic [TOT_W-1:0] elems [STORE_LEN];
        logic [POS_W-1:0] length_reg;
        t_answer          answers [$];
        int               mismatches;
        int               checked;

        function void init();
            foreach (elems[i]) elems[i] = '0;
            length_reg = POS_W'(STORE_LEN);
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_length(logic [POS_W-1:0] value);
            length_reg = value;
        endfunction

        // Called for every accepted input transfer.
        function void note_item(logic [1:0] kind, logic [POS_W-1:0] left,
                                logic [POS_W-1:0] right, logic [ADD_W-1:0] addend);
            t_answer          ans;
            int unsigned      lo, hi, tmp, n;
            logic [TOT_W-1:0] step, acc;
            ans.total = '0;
            ans.status = 1'b0;
            n = (length_reg > STORE_LEN) ? STORE_LEN : length_reg;
            lo = left;
            hi = right;
            if (hi < lo) begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end
            if (kind == KIND_CLEAR) begin
                foreach (elems[i]) elems[i] = '0;
            end else if (kind == KIND_NONE) begin
                ans.status = 1'b0;
            end else if (lo == 0 || hi > n) begin
                ans.status = 1'b1;
            end else if (kind == KIND_ADD) begin
                step = {{(TOT_W-ADD_W){addend[ADD_W-1]}}, addend};
                for (int unsigned p = lo; p <= hi; p++) elems[p-1] += step;
            end else begin
                acc = '0;
                for (int unsigned p = lo; p <= hi; p++) acc += elems[p-1];
                ans.total = acc;
            end
            answers.push_back(ans);
        endfunction

        task report(string what);
            mismatches++;
            $display("%0t ns: mismatch: %s", $time, what);
        endtask

        // Called for every accepted result transfer.
        task check_result(logic [TOT_W-1:0] total, logic status);
            t_answer ans;
            if (answers.size() == 0) begin
                report($sformatf("result with nothing expected, total %0h status %0d",
                                 total, status));
            end else begin
                ans = answers.pop_front();
                checked++;
                if (total !== ans.total)
                    report($sformatf("total %0h, expected %0h", total, ans.total));
                if (status !== ans.status)
                    report($sformatf("status %0d, expected %0d", status, ans.status));
            end
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [1:0]       i_kind = KIND_NONE;
    logic [POS_W-1:0] i_left = '0;
    logic [POS_W-1:0] i_right = '0;
    logic [ADD_W-1:0] i_addend = '0;
    logic             empty;
    logic             pop = 1'b0;
    logic [TOT_W-1:0] o_total;
    logic             o_status;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [POS_W-1:0] i_cfg_length = '0;

    range_scoreboard sb;
    // When calm is set neither side idles; the last part of the run uses it.
    bit              calm = 1'b0;
    // A clear makes the block sweep its whole element memory before it answers.
    bit              clear_since_cfg = 1'b1;
    int              items_sent = 0;
    int              clears_sent = 0;
    int              lengths_used = 0;

    range_add_range_sum_store uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_kind      (i_kind),
        .i_left      (i_left),
        .i_right     (i_right),
        .i_addend    (i_addend),
        .empty       (empty),
        .pop         (pop),
        .o_total     (o_total),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_length(i_cfg_length)
    );

    always #5 i_clk = ~i_clk;

    // Result side: pop changes on the falling edge, stalling in random bursts.
    initial begin
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            pop <= 1'b1;
        end
    end

    // Every result transfer is checked at the rising edge it happens on.
    initial begin
        forever begin
            @(posedge i_clk);
            if (pop && !empty && i_rst_n) sb.check_result(o_total, o_status);
        end
    end

    // Offers one item and returns once the input transfer has happened. An idle
    // burst before the item lowers push first, so push is never lowered and raised
    // in the same step.
    task send_item(logic [1:0] kind, logic [POS_W-1:0] left, logic [POS_W-1:0] right,
                   logic [ADD_W-1:0] addend);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        push <= 1'b1;
        i_kind <= kind;
        i_left <= left;
        i_right <= right;
        i_addend <= addend;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_item(kind, left, right, addend);
        items_sent++;
        if (kind == KIND_CLEAR) begin
            clear_since_cfg = 1'b1;
            clears_sent++;
        end
    endtask

    // Lowers push and waits until every expected result has come back.
    task drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.answers.size() != 0) @(posedge i_clk);
    endtask

    // Writes the length register once the block has surely gone idle. After reset the
    // memory sweep may still run, so after reset or a clear the wait covers a full sweep.
    task write_length(logic [POS_W-1:0] value);
        drain();
        repeat (clear_since_cfg ? STORE_LEN + 2000 : 3000) @(negedge i_clk);
        clear_since_cfg = 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_length <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_length(value);
        lengths_used++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random item for a store of n elements. Most ranges are short so the
    // element walk stays cheap; a few span up to the whole store.
    task random_item(int unsigned n, bit allow_clear);
        int unsigned      pick, lo, hi;
        logic [1:0]       kind;
        logic [POS_W-1:0] left, right;
        pick = $urandom_range(0, 99);
        kind = (pick < 47) ? KIND_ADD : KIND_SUM;
        if (pick == 99) kind = KIND_NONE;
        if (pick == 98 && allow_clear) kind = KIND_CLEAR;
        if (n == 0) begin
            lo = $urandom_range(0, 3);
            hi = $urandom_range(0, 3);
        end else begin
            lo = $urandom_range(1, n);
            if ($urandom_range(0, 19) == 0) hi = $urandom_range(1, n);
            else hi = lo + $urandom_range(0, 600);
            if (hi > n) hi = n;
        end
        left = POS_W'(lo);
        right = POS_W'(hi);
        // Some bounds are broken on purpose: zero, one past the end, or any value.
        case ($urandom_range(0, 39))
            0: left = '0;
            1: right = POS_W'(n + 1);
            2: right = POS_W'($urandom);
            default: ;
        endcase
        if ($urandom_range(0, 1)) {left, right} = {right, left};
        send_item(kind, left, right, $urandom);
    endtask

    initial begin
        int unsigned n;
        sb = new();
        sb.init();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset length; the first write waits out the reset sweep.
        write_length(POS_W'(STORE_LEN));
        send_item(KIND_ADD, 18'd1, 18'd1, 32'h7FFF_FFFF);
        send_item(KIND_ADD, 18'd131072, 18'd131072, 32'h8000_0000);
        send_item(KIND_ADD, 18'd131072, 18'd1, 32'hFFFF_FFFF);
        send_item(KIND_SUM, 18'd1, 18'd131072, 32'hFFFF_FFFF);
        send_item(KIND_SUM, 18'd131072, 18'd1, 32'h0);
        send_item(KIND_SUM, 18'd1, 18'd1, 32'h0);
        send_item(KIND_ADD, 18'd200, 18'd900, 32'h7FFF_FFFF);
        send_item(KIND_SUM, 18'd100, 18'd1000, 32'h0);
        send_item(KIND_SUM, 18'd256, 18'd257, 32'h0);
        send_item(KIND_SUM, 18'd0, 18'd5, 32'h0);
        send_item(KIND_ADD, 18'd5, 18'd131073, 32'h1);
        send_item(KIND_SUM, 18'h3FFFF, 18'h3FFFF, 32'h0);
        send_item(KIND_NONE, 18'h3FFFF, 18'd0, 32'hFFFF_FFFF);
        send_item(KIND_CLEAR, 18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF);
        send_item(KIND_SUM, 18'd1, 18'd131072, 32'h0);

        // Smallest lengths: one element, then none at all.
        write_length(18'd1);
        send_item(KIND_ADD, 18'd1, 18'd1, 32'h1234_5678);
        send_item(KIND_SUM, 18'd1, 18'd1, 32'h0);
        send_item(KIND_SUM, 18'd1, 18'd2, 32'h0);
        write_length(18'd0);
        send_item(KIND_SUM, 18'd1, 18'd1, 32'h0);
        send_item(KIND_ADD, 18'd0, 18'd0, 32'h1);

        // A length above the store is capped; stored values stayed in place.
        write_length(18'h3FFFF);
        send_item(KIND_SUM, 18'd1, 18'd131072, 32'h0);
        send_item(KIND_SUM, 18'd1, 18'd131073, 32'h0);

        // Random part over several lengths; clears are rare because each one sweeps
        // the whole memory.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: n = 300;
                1: n = 1000;
                2: n = $urandom_range(1, STORE_LEN);
                3: n = 5;
                default: n = STORE_LEN;
            endcase
            write_length(POS_W'(n));
            for (int i = 0; i < 110; i++) begin
                if (phase == 4 && i == 50) calm = 1'b1;
                if (phase == 2 && i == 55) drain();
                random_item(n, phase == 1 && clears_sent < 2);
            end
        end

        drain();
        repeat (3000) @(posedge i_clk);
        $display("Covered %0d items, %0d results checked, %0d clears, %0d length settings.",
                 items_sent, sb.checked, clears_sent, lengths_used);
        if (sb.mismatches == 0 && sb.answers.size() == 0) begin
            $display("range_add_range_sum_store verification clean");
        end else begin
            $display("range_add_range_sum_store verification failed");
        end
        $finish;
    end

    // Guard against a hung block: far beyond the slowest correct run.
    initial begin
        #200_000_000;
        $display("Timed out with %0d results still expected.", sb.answers.size());
        $display("range_add_range_sum_store verification failed");
        $finish;
    end

endmodule
